// ===== hw/rtl/rbpl_pkg.sv =====
// shared types and constants for the ring buffer positional list
// no dependencies; used by rbpl_cell and imported by ring_buffer_positional_list
`timescale 1ns / 1ps
`default_nettype none

package rbpl_pkg;

   // fixed field widths of the stream payloads
   localparam int KIND_W      = 3;
   localparam int SLOT_W      = 5;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT     = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_PUSH_BACK  = 3'd2,
      KIND_DELETE     = 3'd3,
      KIND_POP_FRONT  = 3'd4,
      KIND_POP_BACK   = 3'd5,
      KIND_LIST       = 3'd6
   } rbpl_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_BAD_POS = 2'd3
   } rbpl_status_type;

   // per-slot control handed from the sequencer to each ring cell
   typedef struct packed {
      logic load;       // take the new entry value
      logic take_prev;  // shift toward the tail: copy the previous slot
      logic take_next;  // shift back: copy the next slot
   } rbpl_cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ring_buffer_positional_list.sv =====
// flow: a request is captured into the request registers, then the execute state registers a
// single-result op's result in the output register once that is free; list all of n entries
// goes on to the list walk state and gives n result transactions, one per cycle while free
// requests: one at a time; the next request is taken once the previous one has put its
// last result in the output register, and that waits while a held result is not yet taken
// on rsp_tready
// reset: synchronous, clears head, tail, sequencer and output valid; slot contents are
// left as they are and only read once written
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_positional_list #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [4:0] slot_index, [36:5] value, [39:37] zero
   input  wire logic [rbpl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [2:0] kind
   input  wire logic [rbpl_pkg::KIND_W-1:0]      req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [1:0] status, [33:2] entry_value, [38:34] entry_slot, [39] is_empty,
   // [40] is_full, [47:41] zero
   output logic [rbpl_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast
);

   import rbpl_pkg::*;

   // ring geometry
   localparam int RING  = CAPACITY + 1;
   localparam int PTR_W = $clog2(RING);
   localparam logic [PTR_W-1:0] RING_M1 = PTR_W'(RING - 1);
   localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
   localparam logic [PTR_W:0]   RING_X  = (PTR_W + 1)'(RING);
   localparam logic [7:0]       RING_8  = 8'(RING);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LIST = 3'b100
   } state_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == RING_M1) ? '0 : p + PTR_ONE;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      ring_prev = (p == '0) ? RING_M1 : p - PTR_ONE;
   endfunction

   // distance from b forward to a around the ring
   function automatic logic [PTR_W-1:0] ring_sub(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
      logic [PTR_W:0] d;
      d = {1'b0, a} + RING_X - {1'b0, b};
      if (d >= RING_X) begin
         d = d - RING_X;
      end
      ring_sub = d[PTR_W-1:0];
   endfunction

   // sequencer and pointers
   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [PTR_W-1:0]      walk_ff, walk_in;

   // captured request
   rbpl_kind_type         kind_ff, kind_in;
   logic [7:0]            idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rbpl_status_type       rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ring of cells
   rbpl_cell_ctl_type     cell_ctl  [RING];
   logic [DATA_WIDTH-1:0] cell_data [RING];

   // request decode helpers
   logic [63:0]           req_value64;
   logic                  out_free;
   logic                  empty_now, full_now;
   logic [PTR_W-1:0]      count;
   logic                  idx_valid;
   logic [PTR_W-1:0]      idx_p, idx_off;
   logic                  in_span, at_tail;

   // chosen operation
   rbpl_status_type       op_status;
   logic [PTR_W-1:0]      head_nx, tail_nx;
   logic                  do_ins, do_del, do_pf, do_pb, apply;

   // list walk read
   logic [DATA_WIDTH-1:0] walk_data;
   logic [63:0]           walk_data64;
   logic [7:0]            walk_slot8;
   logic                  walk_last;

   assign req_tready  = (state_ff == S_IDLE);
   assign req_value64 = {32'b0, req_tdata[SLOT_W +: VALUE_W]};
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // span arithmetic on the current pointers
   assign empty_now = (head_ff == tail_ff);
   assign full_now  = (ring_next(tail_ff) == head_ff);
   assign count     = ring_sub(tail_ff, head_ff);
   assign idx_valid = (idx_ff < RING_8);
   assign idx_p     = idx_ff[PTR_W-1:0];
   assign idx_off   = ring_sub(idx_p, head_ff);
   assign in_span   = idx_valid && (idx_off < count);
   assign at_tail   = idx_valid && (idx_p == tail_ff);

   // single-result operations decided from the captured request
   always_comb begin
      op_status = STATUS_OK;
      head_nx   = head_ff;
      tail_nx   = tail_ff;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      do_pf     = 1'b0;
      do_pb     = 1'b0;
      case (kind_ff)
         KIND_INSERT: begin
            if (full_now) begin
               op_status = STATUS_FULL;
            end else if (!(in_span || at_tail)) begin
               op_status = STATUS_BAD_POS;
            end else begin
               do_ins  = 1'b1;
               tail_nx = ring_next(tail_ff);
            end
         end
         KIND_PUSH_FRONT: begin
            if (full_now) begin
               op_status = STATUS_FULL;
            end else begin
               do_pf   = 1'b1;
               head_nx = ring_prev(head_ff);
            end
         end
         KIND_PUSH_BACK: begin
            if (full_now) begin
               op_status = STATUS_FULL;
            end else begin
               do_pb   = 1'b1;
               tail_nx = ring_next(tail_ff);
            end
         end
         KIND_DELETE: begin
            if (empty_now) begin
               op_status = STATUS_EMPTY;
            end else if (!in_span) begin
               op_status = STATUS_BAD_POS;
            end else begin
               do_del  = 1'b1;
               tail_nx = ring_prev(tail_ff);
            end
         end
         KIND_POP_FRONT: begin
            if (empty_now) begin
               op_status = STATUS_EMPTY;
            end else begin
               head_nx = ring_next(head_ff);
            end
         end
         KIND_POP_BACK: begin
            if (empty_now) begin
               op_status = STATUS_EMPTY;
            end else begin
               tail_nx = ring_prev(tail_ff);
            end
         end
         KIND_LIST: begin
            // only reaches a single result when the list is empty
            op_status = STATUS_EMPTY;
         end
         default: begin
            op_status = STATUS_BAD_POS;
         end
      endcase
   end

   // ops act on the ring only in the cycle the result is registered
   assign apply = (state_ff == S_EXEC) && out_free &&
                  !((kind_ff == KIND_LIST) && !empty_now);

   // per-cell control: each cell checks its own offset from head
   always_comb begin
      logic [PTR_W-1:0] off_c;
      for (int c = 0; c < RING; c++) begin
         off_c = ring_sub(PTR_W'(c), head_ff);
         cell_ctl[c].load =
            apply && ((do_ins && (PTR_W'(c) == idx_p)) ||
                      (do_pf && (PTR_W'(c) == ring_prev(head_ff))) ||
                      (do_pb && (PTR_W'(c) == tail_ff)));
         // insert: slots after the position up to the old tail move up one
         cell_ctl[c].take_prev = apply && do_ins && (idx_off < off_c) && (off_c <= count);
         // delete: slots from the position up to the one before the last move back
         cell_ctl[c].take_next = apply && do_del && (idx_off <= off_c) &&
                                 (off_c + PTR_ONE < count);
      end
   end

   // the ring itself: every cell sees both neighbors
   for (genvar g = 0; g < RING; g++) begin : g_slots
      localparam int PREV = (g == 0) ? RING - 1 : g - 1;
      localparam int NEXT = (g == RING - 1) ? 0 : g + 1;
      rbpl_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_slot (
         .clock     (clock),
         .ctl       (cell_ctl[g]),
         .prev_data (cell_data[PREV]),
         .next_data (cell_data[NEXT]),
         .load_data (value_ff),
         .data_out  (cell_data[g])
      );
   end

   // list walk: one slot per cycle while the output register is free, from head to the slot before tail
   assign walk_data   = cell_data[walk_ff];
   assign walk_data64 = 64'(walk_data);
   assign walk_slot8  = 8'(walk_ff);
   assign walk_last   = (ring_next(walk_ff) == tail_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      walk_in       = walk_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = rbpl_kind_type'(req_tuser);
               idx_in   = {3'b0, req_tdata[SLOT_W-1:0]};
               value_in = req_value64[DATA_WIDTH-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((kind_ff == KIND_LIST) && !empty_now) begin
               walk_in  = head_ff;
               state_in = S_LIST;
            end else if (out_free) begin
               head_in       = head_nx;
               tail_in       = tail_nx;
               rsp_valid_in  = 1'b1;
               rsp_status_in = op_status;
               rsp_value_in  = '0;
               rsp_slot_in   = '0;
               rsp_empty_in  = (head_nx == tail_nx);
               rsp_full_in   = (ring_next(tail_nx) == head_nx);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = walk_data64[VALUE_W-1:0];
               rsp_slot_in   = walk_slot8[SLOT_W-1:0];
               rsp_empty_in  = empty_now;
               rsp_full_in   = full_now;
               rsp_last_in   = walk_last;
               walk_in       = ring_next(walk_ff);
               if (walk_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'b0, rsp_full_ff, rsp_empty_ff, rsp_slot_ff, rsp_value_ff,
                        rsp_status_ff};

   // pointers always name a real slot of the ring
   assert property (@(posedge clock) disable iff (reset)
      (head_ff <= RING_M1) && (tail_ff <= RING_M1))
      else $error("ring pointer out of range");

   // a list walk only runs over a non-empty list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> (head_ff != tail_ff))
      else $error("list walk over empty list");

   // head and tail move only when an operation is applied
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EXEC) |=> ($stable(head_ff) && $stable(tail_ff)))
      else $error("pointer changed outside execute");

endmodule

`default_nettype wire

// ===== hw/rtl/rbpl_cell.sv =====
// one ring slot: holds an entry and can take its neighbor's entry or a new value
// depends on rbpl_pkg for the cell control struct
`timescale 1ns / 1ps
`default_nettype none

module rbpl_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire rbpl_pkg::rbpl_cell_ctl_type   ctl,
   input  wire logic [DATA_WIDTH-1:0]         prev_data,
   input  wire logic [DATA_WIDTH-1:0]         next_data,
   input  wire logic [DATA_WIDTH-1:0]         load_data,
   output logic      [DATA_WIDTH-1:0]         data_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.take_prev) begin
         data_in = prev_data;
      end else if (ctl.take_next) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire
